>>> rtl/bounded_double_ended_queue_defines.svh
// assertion macros for the deque checker
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_DEFINES_SVH

// same-cycle implication
`define BDEQ_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("deque check failed");

// next-cycle implication
`define BDEQ_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("deque check failed");

`endif

>>> rtl/bdeq_pkg.sv
// shared codes and types for the deque
package bdeq_pkg;

  localparam int DATA_W = 32;

  typedef logic [2:0] mode_t;
  localparam mode_t MODE_PUSH_FRONT = 3'd0;
  localparam mode_t MODE_PUSH_BACK  = 3'd1;
  localparam mode_t MODE_POP_FRONT  = 3'd2;
  localparam mode_t MODE_POP_BACK   = 3'd3;
  localparam mode_t MODE_DUMP       = 3'd4;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  typedef logic [2:0] cell_op_t;
  localparam cell_op_t OP_HOLD       = 3'd0;
  localparam cell_op_t OP_PUSH_FRONT = 3'd1;
  localparam cell_op_t OP_PUSH_BACK  = 3'd2;
  localparam cell_op_t OP_POP_FRONT  = 3'd3;
  localparam cell_op_t OP_POP_BACK   = 3'd4;
  localparam cell_op_t OP_ROTATE     = 3'd5;

  typedef struct packed {
    cell_op_t                  op;
    logic signed [DATA_W-1:0]  bcast;
  } cell_ctrl_t;

endpackage

>>> rtl/bounded_double_ended_queue.sv
// deque top level: chain of cells, control and output register
//
//   channel | dir | tdata            | tuser          | tlast
//   s_*     | in  | value [31:0]     | mode [2:0]     | -
//   m_*     | out | item [31:0]      | status [1:0]   | last
//
// push and pop: taken back to back while the output register is free, result in the output register next cycle
// dump: started from idle, then one beat per stored value, front to back
// dump rotates the cell chain so the contents are back in order at the end
// reset clears the cell valid bits at once, no clearing pass
// m_tready low while m_tvalid is high holds the output register and stops input and dump progress
module bounded_double_ended_queue #(
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic signed [bdeq_pkg::DATA_W-1:0]   s_tdata,   // value
  input  logic [2:0]                           s_tuser,   // mode
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic signed [bdeq_pkg::DATA_W-1:0]   m_tdata,   // item
  output logic [1:0]                           m_tuser,   // status
  output logic                                 m_tlast
);
  import bdeq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  logic                       state, state_next;
  logic [CW-1:0]              cnt, cnt_next;
  logic [CW-1:0]              rem, rem_next;

  logic signed [DATA_W-1:0]   cdata [DEPTH];
  logic [DEPTH-1:0]           cvalid;
  logic [DEPTH-1:0]           cback;
  logic signed [DATA_W-1:0]   back_val;
  cell_ctrl_t                 ctrl;
  cell_op_t                   op;

  logic                       out_free;
  logic                       accept;
  logic                       ld_out;
  logic signed [DATA_W-1:0]   o_item;
  status_t                    o_status;
  logic                       o_last;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [DATA_W-1:0] ldata, rdata;
      logic                     lvalid, rvalid;
      if (g == 0) begin : g_first
        assign ldata  = s_tdata;
        assign lvalid = 1'b1;
      end else begin : g_mid_l
        assign ldata  = cdata[g-1];
        assign lvalid = cvalid[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
        assign rdata  = '0;
        assign rvalid = 1'b0;
      end else begin : g_mid_r
        assign rdata  = cdata[g+1];
        assign rvalid = cvalid[g+1];
      end
      bdeq_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctrl        (ctrl),
        .left_data   (ldata),
        .left_valid  (lvalid),
        .right_data  (rdata),
        .right_valid (rvalid),
        .data        (cdata[g]),
        .valid       (cvalid[g]),
        .back        (cback[g])
      );
    end
  endgenerate

  // one-hot select of the back cell
  always_comb begin
    back_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_val = back_val | (cdata[i] & {DATA_W{cback[i]}});
    end
  end

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    op         = OP_HOLD;
    ld_out     = 1'b0;
    o_item     = '0;
    o_status   = ST_OK;
    o_last     = 1'b1;
    state_next = state;
    cnt_next   = cnt;
    rem_next   = rem;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (s_tuser)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
              ld_out = 1'b1;
              if (cvalid[DEPTH-1]) begin
                o_status = ST_FULL;
              end else begin
                op       = (s_tuser == MODE_PUSH_FRONT) ? OP_PUSH_FRONT : OP_PUSH_BACK;
                cnt_next = cnt + CW'(1);
              end
            end
            MODE_POP_FRONT, MODE_POP_BACK: begin
              ld_out = 1'b1;
              if (!cvalid[0]) begin
                o_status = ST_EMPTY;
              end else begin
                op       = (s_tuser == MODE_POP_FRONT) ? OP_POP_FRONT : OP_POP_BACK;
                o_item   = (s_tuser == MODE_POP_FRONT) ? cdata[0] : back_val;
                cnt_next = cnt - CW'(1);
              end
            end
            MODE_DUMP: begin
              if (!cvalid[0]) begin
                ld_out   = 1'b1;
                o_status = ST_EMPTY;
              end else begin
                state_next = S_DUMP;
                rem_next   = cnt;
              end
            end
            default: begin
              op = OP_HOLD;
            end
          endcase
        end
      end
      S_DUMP: begin
        if (out_free) begin
          ld_out   = 1'b1;
          o_item   = cdata[0];
          o_last   = (rem == CW'(1));
          op       = OP_ROTATE;
          rem_next = rem - CW'(1);
          if (rem == CW'(1)) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign ctrl.op    = op;
  assign ctrl.bcast = (op == OP_ROTATE) ? cdata[0] : s_tdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      rem      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      rem   <= rem_next;
      if (ld_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      m_tdata <= o_item;
      m_tuser <= o_status;
      m_tlast <= o_last;
    end
  end

endmodule

>>> rtl/bdeq_cell.sv
// one storage cell of the deque chain
module bdeq_cell (
  input  logic                                 clk,
  input  logic                                 rst,
  input  bdeq_pkg::cell_ctrl_t                 ctrl,
  input  logic signed [bdeq_pkg::DATA_W-1:0]   left_data,
  input  logic                                 left_valid,
  input  logic signed [bdeq_pkg::DATA_W-1:0]   right_data,
  input  logic                                 right_valid,
  output logic signed [bdeq_pkg::DATA_W-1:0]   data,
  output logic                                 valid,
  output logic                                 back
);
  import bdeq_pkg::*;

  assign back = valid && !right_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (ctrl.op)
        OP_PUSH_FRONT: valid <= left_valid;
        OP_PUSH_BACK:  valid <= valid || left_valid;
        OP_POP_FRONT:  valid <= right_valid;
        OP_POP_BACK:   valid <= valid && right_valid;
        default:       valid <= valid;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_PUSH_FRONT: data <= left_data;
      OP_PUSH_BACK: begin
        if (!valid && left_valid) begin
          data <= ctrl.bcast;
        end
      end
      OP_POP_FRONT: data <= right_data;
      OP_ROTATE: begin
        if (back) begin
          data <= ctrl.bcast;
        end else if (valid) begin
          data <= right_data;
        end
      end
      default: data <= data;
    endcase
  end

endmodule

>>> rtl/bdeq_check.sv
// port checker for the deque, bound to the top level
module bdeq_check (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 s_tvalid,
  input logic                                 s_tready,
  input logic signed [bdeq_pkg::DATA_W-1:0]   s_tdata,
  input logic [2:0]                           s_tuser,
  input logic                                 m_tvalid,
  input logic                                 m_tready,
  input logic signed [bdeq_pkg::DATA_W-1:0]   m_tdata,
  input logic [1:0]                           m_tuser,
  input logic                                 m_tlast
);
  import bdeq_pkg::*;
  `include "bounded_double_ended_queue_defines.svh"

  logic in_beat;
  logic single_op;

  assign in_beat   = s_tvalid && s_tready;
  assign single_op = (s_tuser == MODE_PUSH_FRONT) || (s_tuser == MODE_PUSH_BACK) ||
                     (s_tuser == MODE_POP_FRONT) || (s_tuser == MODE_POP_BACK);

  `BDEQ_ASSERT_NOW(a_no_take_when_stalled, m_tvalid && !m_tready, !s_tready)
  `BDEQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `BDEQ_ASSERT_NOW(a_error_beat_shape, m_tvalid && (m_tuser != ST_OK),
                   m_tlast && (m_tdata == 0))
  `BDEQ_ASSERT_NEXT(a_single_op_result, in_beat && single_op, m_tvalid && m_tlast)

endmodule

bind bounded_double_ended_queue bdeq_check u_bdeq_check (.*);
